@@ sv/ftrh_pkg.sv @@
// Package: shared types and function codes for the timed-retry work queue.
package ftrh_pkg;

    typedef enum logic [1:0] {
        FN_ENQ   = 2'd0,
        FN_REQ   = 2'd1,
        FN_DEQ   = 2'd2,
        FN_SHUT  = 2'd3
    } t_func;

    localparam int TAG_W  = 16;
    localparam int BYTE_W = 40;
    localparam int TIME_W = 48;
    localparam int TOT_W  = 48;
    localparam int ENT_W  = TAG_W + BYTE_W + TIME_W;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [BYTE_W-1:0] bytes;
        logic [TIME_W-1:0] rtime;
    } t_entry;

endpackage

@@ sv/fifo_with_timed_retry_heap_unit.sv @@
// Top level: timed-retry work queue, ready FIFO plus min-heap in RAMs.
// Enqueue, shutdown, FIFO requeue, rejected requeue and requeue into an empty heap finish in
// the dispatch state; other heap requeues sift up level by level; a dequeue after shutdown
// returns no item, else it promotes due heap roots to the FIFO, sifting each replacement down,
// then reads the FIFO head. Throughput: one item at a time; busy stays high until its result strobe.
// Reset: synchronous active-low; counters, totals, shutdown flag and limit clear, RAM
// contents stay undefined and are only read once written. The receiver cannot stall.
module fifo_with_timed_retry_heap_unit
    import ftrh_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int HEAP_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [8:0]                    i_cfg_data,
    input  logic [1:0]                    i_func,
    input  logic [TIME_W-1:0]             i_now_time,
    input  logic [TAG_W-1:0]              i_item_tag,
    input  logic [BYTE_W-1:0]             i_item_bytes,
    input  logic [TIME_W-1:0]             i_retry_time,
    output logic                          o_strobe,
    output logic                          o_accepted,
    output logic                          o_item_valid,
    output logic [TAG_W-1:0]              o_out_tag,
    output logic [BYTE_W-1:0]             o_out_bytes,
    output logic [TIME_W-1:0]             o_out_retry_time,
    output logic [8:0]                    o_ready_count,
    output logic [6:0]                    o_delayed_count,
    output logic                          o_all_empty,
    output logic [TOT_W-1:0]              o_pending_total,
    output logic                          o_is_shut_down
);

    localparam int FA_W = $clog2(FIFO_DEPTH);
    localparam int HA_W = $clog2(HEAP_DEPTH);
    localparam int FC_W = $clog2(FIFO_DEPTH + 1);
    localparam int HC_W = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DONE  = 12'b000000000010,
        S_UPRD  = 12'b000000000100, // read parent during sift-up
        S_UPCMP = 12'b000000001000,
        S_PRRD  = 12'b000000010000, // read heap root for promotion
        S_PRCHK = 12'b000000100000,
        S_LSTRD = 12'b000001000000, // read last entry
        S_DNRD  = 12'b000010000000, // read left child
        S_DNRR  = 12'b000100000000, // read right child
        S_DNCMP = 12'b001000000000,
        S_FHRD  = 12'b010000000000, // read FIFO head
        S_FHOUT = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // request latch
    t_func             r_func;
    logic [TIME_W-1:0] r_now;
    t_entry            r_in;

    // control state
    logic [FA_W-1:0]  r_head, r_tail;
    logic [FC_W-1:0]  r_ffill;
    logic [HC_W-1:0]  r_hfill;
    logic [TOT_W-1:0] r_total;
    logic             r_shut;
    logic [8:0]       r_limit;

    // sift working registers
    logic [HA_W-1:0] r_idx, r_cidx;
    t_entry          r_cur, r_lch;
    logic            r_has_r;

    // RAM ports
    logic            f_we;
    logic [FA_W-1:0] f_wa, f_ra;
    t_entry          f_wd, f_rd;
    logic            h_we;
    logic [HA_W-1:0] h_wa, h_ra;
    t_entry          h_wd, h_rd;

    ftrh_ram #(.WIDTH(ENT_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_raddr(f_ra), .o_rdata(f_rd)
    );

    ftrh_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );

    // next-state registers
    logic [FA_W-1:0]  n_head, n_tail;
    logic [FC_W-1:0]  n_ffill;
    logic [HC_W-1:0]  n_hfill;
    logic [TOT_W-1:0] n_total;
    logic             n_shut;
    logic [HA_W-1:0]  n_idx, n_cidx;
    t_entry           n_cur, n_lch;
    logic             n_has_r;
    logic             n_strobe, n_acc, n_valid;
    t_entry           n_out;

    logic             fifo_full, heap_full, limit_hit;
    logic [HA_W:0]    l_wide, r_wide;
    logic [HC_W-1:0]  last_w;
    t_entry           child;
    logic             take_r;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign fifo_full   = (r_ffill == FC_W'(FIFO_DEPTH));
    assign heap_full   = (r_hfill == HC_W'(HEAP_DEPTH));
    assign limit_hit   = (r_limit != 9'd0) && ({23'd0, r_limit} <= 32'(r_ffill));

    // child addresses of r_idx
    assign l_wide = {r_idx, 1'b1};
    assign r_wide = l_wide + (HA_W+1)'(1);
    assign last_w = r_hfill;
    assign take_r = r_has_r && (h_rd.rtime < r_lch.rtime);
    assign child  = take_r ? h_rd : r_lch;

    always_comb begin
        n_state = r_state;
        n_head = r_head; n_tail = r_tail; n_ffill = r_ffill; n_hfill = r_hfill;
        n_total = r_total; n_shut = r_shut;
        n_idx = r_idx; n_cidx = r_cidx; n_cur = r_cur; n_lch = r_lch; n_has_r = r_has_r;
        n_strobe = 1'b0; n_acc = 1'b0; n_valid = 1'b0; n_out = '0;
        f_we = 1'b0; f_wa = r_tail; f_wd = r_in; f_ra = r_head;
        h_we = 1'b0; h_wa = r_idx; h_wd = r_cur; h_ra = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // dispatch the latched request
                n_state = S_IDLE;
                n_strobe = 1'b1;
                case (r_func)
                    FN_ENQ: begin
                        if (!limit_hit && !fifo_full) begin
                            f_we = 1'b1;
                            n_tail = r_tail + FA_W'(1);
                            n_ffill = r_ffill + FC_W'(1);
                            n_total = r_total + TOT_W'(r_in.bytes);
                            n_acc = 1'b1;
                        end
                    end
                    FN_REQ: begin
                        if (r_in.rtime <= r_now) begin
                            if (!fifo_full) begin
                                f_we = 1'b1;
                                n_tail = r_tail + FA_W'(1);
                                n_ffill = r_ffill + FC_W'(1);
                                n_total = r_total + TOT_W'(r_in.bytes);
                                n_acc = 1'b1;
                            end
                        end else if (!heap_full) begin
                            n_total = r_total + TOT_W'(r_in.bytes);
                            n_hfill = r_hfill + HC_W'(1);
                            n_idx = HA_W'(r_hfill);
                            n_cur = r_in;
                            n_acc = 1'b1;
                            n_strobe = 1'b0;
                            if (r_hfill == '0) begin
                                h_we = 1'b1; h_wa = '0; h_wd = r_in;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_UPRD;
                            end
                        end
                    end
                    FN_DEQ: begin
                        n_strobe = 1'b0;
                        if (r_shut) begin
                            n_strobe = 1'b1;
                        end else begin
                            h_ra = '0;
                            n_state = S_PRRD;
                        end
                    end
                    default: begin
                        n_shut = 1'b1;
                    end
                endcase
            end
            S_UPRD: begin
                // at the root the new entry lands, else fetch the parent
                if (r_idx == '0) begin
                    h_we = 1'b1; h_wa = '0; h_wd = r_cur;
                    n_state = S_IDLE;
                    n_strobe = 1'b1; n_acc = 1'b1;
                end else begin
                    n_cidx = HA_W'((r_idx - HA_W'(1)) >> 1);
                    h_ra = HA_W'((r_idx - HA_W'(1)) >> 1);
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (h_rd.rtime > r_cur.rtime) begin
                    // move parent down, continue upward
                    h_we = 1'b1; h_wa = r_idx; h_wd = h_rd;
                    n_idx = r_cidx;
                    n_state = S_UPRD;
                end else begin
                    h_we = 1'b1; h_wa = r_idx; h_wd = r_cur;
                    n_state = S_IDLE;
                    n_strobe = 1'b1; n_acc = 1'b1;
                end
            end
            S_PRRD: begin
                // re-read the root after any write to it has settled
                h_ra = '0;
                n_state = S_PRCHK;
            end
            S_PRCHK: begin
                // root in h_rd
                if (r_hfill != '0 && h_rd.rtime <= r_now && !fifo_full) begin
                    f_we = 1'b1; f_wd = h_rd;
                    n_tail = r_tail + FA_W'(1);
                    n_ffill = r_ffill + FC_W'(1);
                    n_hfill = r_hfill - HC_W'(1);
                    if (r_hfill == HC_W'(1)) begin
                        n_state = S_FHRD;
                    end else begin
                        h_ra = HA_W'(r_hfill - HC_W'(1));
                        n_idx = '0;
                        n_state = S_LSTRD;
                    end
                end else begin
                    n_state = S_FHRD;
                end
            end
            S_LSTRD: begin
                // last entry becomes the one sifted down from the root
                n_cur = h_rd;
                n_state = S_DNRD;
            end
            S_DNRD: begin
                if (l_wide >= (HA_W+1)'(last_w)) begin
                    h_we = 1'b1; h_wa = r_idx; h_wd = r_cur;
                    h_ra = '0;
                    n_state = S_PRRD;
                end else begin
                    h_ra = l_wide[HA_W-1:0];
                    n_state = S_DNRR;
                end
            end
            S_DNRR: begin
                n_has_r = !r_wide[HA_W] && ((HA_W+1)'(last_w) > r_wide);
                h_ra = r_wide[HA_W-1:0];
                n_state = S_DNCMP;
                n_lch = h_rd;
            end
            S_DNCMP: begin
                if (child.rtime < r_cur.rtime) begin
                    h_we = 1'b1; h_wa = r_idx; h_wd = child;
                    n_idx = take_r ? r_wide[HA_W-1:0] : l_wide[HA_W-1:0];
                    n_state = S_DNRD;
                end else begin
                    h_we = 1'b1; h_wa = r_idx; h_wd = r_cur;
                    h_ra = '0;
                    n_state = S_PRRD;
                end
            end
            S_FHRD: begin
                n_state = S_FHOUT;
            end
            S_FHOUT: begin
                n_state = S_IDLE;
                n_strobe = 1'b1;
                if (r_ffill != '0) begin
                    n_valid = 1'b1;
                    n_out = f_rd;
                    n_head = r_head + FA_W'(1);
                    n_ffill = r_ffill - FC_W'(1);
                    n_total = r_total - TOT_W'(f_rd.bytes);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0; r_tail <= '0; r_ffill <= '0; r_hfill <= '0;
            r_total <= '0; r_shut <= 1'b0; r_limit <= '0;
            o_strobe <= 1'b0;
            r_cidx <= '0;
        end else begin
            r_state <= n_state;
            r_head <= n_head; r_tail <= n_tail; r_ffill <= n_ffill; r_hfill <= n_hfill;
            r_total <= n_total; r_shut <= n_shut;
            o_strobe <= n_strobe;
            r_cidx <= n_cidx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_func <= t_func'(i_func);
            r_now <= i_now_time;
            r_in <= '{tag: i_item_tag, bytes: i_item_bytes, rtime: i_retry_time};
        end
        r_idx <= n_idx; r_cur <= n_cur; r_lch <= n_lch; r_has_r <= n_has_r;
        if (n_strobe) begin
            o_accepted <= n_acc;
            o_item_valid <= n_valid;
            o_out_tag <= n_out.tag;
            o_out_bytes <= n_out.bytes;
            o_out_retry_time <= n_out.rtime;
            o_ready_count <= 9'(n_ffill);
            o_delayed_count <= 7'(n_hfill);
            o_all_empty <= (n_ffill == '0) && (n_hfill == '0);
            o_pending_total <= n_total;
            o_is_shut_down <= n_shut;
        end
    end

    // a result strobe only ends a busy period
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("strobe without work");
    // fills never exceed storage
    a_ffill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ffill <= FC_W'(FIFO_DEPTH)) else $error("fifo overfill");
    a_hfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hfill <= HC_W'(HEAP_DEPTH)) else $error("heap overfill");

endmodule

@@ sv/ftrh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ftrh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ tb/sv/tb_fifo_with_timed_retry_heap_unit.sv @@
// Testbench for the timed-retry work queue: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_fifo_with_timed_retry_heap_unit;
    import ftrh_pkg::*;

    localparam int QDEPTH = 256;
    localparam int HDEPTH = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic              accepted;
        logic              item_valid;
        logic [15:0]       tag;
        logic [39:0]       bytes;
        logic [47:0]       rtime;
        logic [8:0]        ready_count;
        logic [6:0]        delayed_count;
        logic              all_empty;
        logic [47:0]       pending;
        logic              shut;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [8:0] i_cfg_data = '0;
    logic [1:0] i_func = '0;
    logic [47:0] i_now_time = '0;
    logic [15:0] i_item_tag = '0;
    logic [39:0] i_item_bytes = '0;
    logic [47:0] i_retry_time = '0;
    logic o_strobe, o_accepted, o_item_valid, o_all_empty, o_is_shut_down;
    logic [15:0] o_out_tag;
    logic [39:0] o_out_bytes;
    logic [47:0] o_out_retry_time, o_pending_total;
    logic [8:0] o_ready_count;
    logic [6:0] o_delayed_count;

    fifo_with_timed_retry_heap_unit u_dut (.*);

    // predictor state
    t_entry      ready_q[$];
    t_entry      retry_heap[HDEPTH];
    int          heap_n;
    logic [47:0] byte_sum;
    logic        shut_seen;
    logic [8:0]  limit_reg;
    logic [47:0] clock_now;

    t_status expected_q[$];
    int      errors;
    int      checked;
    int      dq_hits;
    int      promos;
    bit      no_idle;
    longint  cycles;

    initial forever #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_status w;
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                w = expected_q.pop_front();
                checked++;
                if (o_accepted !== w.accepted) report("accepted", o_accepted, w.accepted);
                if (o_item_valid !== w.item_valid) report("item_valid", o_item_valid, w.item_valid);
                if (o_out_tag !== w.tag) report("out_tag", o_out_tag, w.tag);
                if (o_out_bytes !== w.bytes) report("out_bytes", o_out_bytes, w.bytes);
                if (o_out_retry_time !== w.rtime)
                    report("out_retry_time", o_out_retry_time, w.rtime);
                if (o_ready_count !== w.ready_count)
                    report("ready_count", o_ready_count, w.ready_count);
                if (o_delayed_count !== w.delayed_count)
                    report("delayed_count", o_delayed_count, w.delayed_count);
                if (o_all_empty !== w.all_empty) report("all_empty", o_all_empty, w.all_empty);
                if (o_pending_total !== w.pending)
                    report("pending_total", o_pending_total, w.pending);
                if (o_is_shut_down !== w.shut) report("is_shut_down", o_is_shut_down, w.shut);
            end
        end
    end

    function automatic void heap_insert(input t_entry e);
        int i, p;
        t_entry t;
        i = heap_n;
        retry_heap[i] = e;
        heap_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (retry_heap[i].rtime < retry_heap[p].rtime) begin
                t = retry_heap[i]; retry_heap[i] = retry_heap[p]; retry_heap[p] = t;
                i = p;
            end else break;
        end
    endfunction

    function automatic void heap_remove_min();
        int i, l, r, c;
        t_entry t;
        i = 0;
        heap_n--;
        if (heap_n == 0) return;
        retry_heap[0] = retry_heap[heap_n];
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            if (l >= heap_n) break;
            c = l;
            if (r < heap_n && retry_heap[r].rtime < retry_heap[l].rtime) c = r;
            if (retry_heap[c].rtime < retry_heap[i].rtime) begin
                t = retry_heap[c]; retry_heap[c] = retry_heap[i]; retry_heap[i] = t;
                i = c;
            end else break;
        end
    endfunction

    // queue predictor: one status per item
    function automatic t_status predict_status(t_func fn, logic [47:0] now, t_entry e);
        t_status s;
        bit over;
        s = '0;
        case (fn)
            FN_ENQ: begin
                over = (limit_reg != 0 && ready_q.size() >= limit_reg) || ready_q.size() >= QDEPTH;
                if (!over) begin
                    ready_q.push_back(e);
                    byte_sum += e.bytes;
                    s.accepted = 1'b1;
                end
            end
            FN_REQ: begin
                if (e.rtime <= now) begin
                    if (ready_q.size() < QDEPTH) begin
                        ready_q.push_back(e);
                        byte_sum += e.bytes;
                        s.accepted = 1'b1;
                    end
                end else if (heap_n < HDEPTH) begin
                    heap_insert(e);
                    byte_sum += e.bytes;
                    s.accepted = 1'b1;
                end
            end
            FN_DEQ: begin
                if (!shut_seen) begin
                    while (heap_n > 0 && retry_heap[0].rtime <= now && ready_q.size() < QDEPTH) begin
                        ready_q.push_back(retry_heap[0]);
                        heap_remove_min();
                        promos++;
                    end
                    if (ready_q.size() > 0) begin
                        t_entry h;
                        h = ready_q.pop_front();
                        s.item_valid = 1'b1;
                        s.tag = h.tag;
                        s.bytes = h.bytes;
                        s.rtime = h.rtime;
                        byte_sum -= h.bytes;
                        dq_hits++;
                    end
                end
            end
            default: shut_seen = 1'b1;
        endcase
        s.ready_count = 9'(ready_q.size());
        s.delayed_count = 7'(heap_n);
        s.all_empty = (ready_q.size() == 0 && heap_n == 0);
        s.pending = byte_sum;
        s.shut = shut_seen;
        return s;
    endfunction

    task automatic idle_gap();
        if (!no_idle) while ($urandom_range(99) < 23) @(negedge i_clk);
    endtask

    // send one item and predict its result
    task automatic send_item(t_func fn, logic [47:0] now, logic [15:0] tag, logic [39:0] nb,
                             logic [47:0] rt);
        t_entry e;
        idle_gap();
        i_func = fn;
        i_now_time = now;
        i_item_tag = tag;
        i_item_bytes = nb;
        i_retry_time = rt;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e.tag = tag; e.bytes = nb; e.rtime = rt;
        expected_q.push_back(predict_status(fn, now, e));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [8:0] v);
        drain_results();
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [39:0] rand40();
        return 40'({$urandom(), $urandom()});
    endfunction

    // directed: extremes, enqueue, requeue and dequeue
    task automatic test_directed();
        write_limit(9'd2);
        send_item(FN_DEQ, 48'd0, 16'h0, 40'h0, 48'h0);
        send_item(FN_ENQ, 48'd5, 16'hFFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(FN_ENQ, 48'd5, 16'h0000, 40'h0, 48'h0);
        send_item(FN_ENQ, 48'd5, 16'h1234, 40'h1, 48'h1);
        send_item(FN_REQ, 48'd100, 16'hAAAA, 40'h55_5555_5555, 48'd100);
        send_item(FN_REQ, 48'd100, 16'h5555, 40'hAA_AAAA_AAAA, 48'd101);
        send_item(FN_REQ, 48'd100, 16'h0001, 40'h10, 48'd101);
        send_item(FN_REQ, 48'd100, 16'h0002, 40'h20, 48'hFFFF_FFFF_FFFF);
        send_item(FN_REQ, 48'hFFFF_FFFF_FFFF, 16'h0003, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        repeat (6) send_item(FN_DEQ, 48'd101, 16'hFFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(FN_DEQ, 48'hFFFF_FFFF_FFFF, 16'h0, 40'h0, 48'h0);
        send_item(FN_DEQ, 48'hFFFF_FFFF_FFFF, 16'h0, 40'h0, 48'h0);
    endtask

    // fill both stores to their physical limits, byte total wraps
    task automatic test_full_stores();
        write_limit(9'd0);
        for (int k = 0; k < QDEPTH + 2; k++)
            send_item(FN_ENQ, 48'd0, k[15:0], 40'hFF_FFFF_FFFF, 48'd0);
        send_item(FN_REQ, 48'd9, 16'h7777, 40'h1, 48'd3);
        for (int k = 0; k < HDEPTH + 2; k++)
            send_item(FN_REQ, 48'd0, 16'($urandom()), rand40(), 48'd10 + $urandom_range(5));
        send_item(FN_DEQ, 48'd20, 16'h0, 40'h0, 48'h0);
        send_item(FN_DEQ, 48'd20, 16'h0, 40'h0, 48'h0);
        write_limit(9'd256);
        send_item(FN_ENQ, 48'd0, 16'h8888, 40'h2, 48'd0);
        for (int k = 0; k < QDEPTH + HDEPTH + 4; k++)
            send_item(FN_DEQ, 48'hFFFF_FFFF_FFFF, 16'h0, 40'h0, 48'h0);
    endtask

    // random traffic with a time that mostly moves forward
    task automatic test_random(int n, logic [8:0] lim);
        int r;
        logic [47:0] rt;
        write_limit(lim);
        for (int k = 0; k < n; k++) begin
            no_idle = (k >= n / 3 && k < n / 2);
            if ($urandom_range(19) == 0) clock_now = rand48();
            else clock_now += $urandom_range(8);
            r = $urandom_range(99);
            rt = ($urandom_range(9) == 0) ? rand48() : clock_now + $urandom_range(30) - 10;
            if (r < 30)
                send_item(FN_ENQ, clock_now, 16'($urandom()), rand40(), rand48());
            else if (r < 60)
                send_item(FN_REQ, clock_now, 16'($urandom()), rand40(), rt);
            else
                send_item(FN_DEQ, clock_now, 16'($urandom()), rand40(), rand48());
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_shutdown();
        write_limit(9'd1);
        send_item(FN_SHUT, 48'd0, 16'h0, 40'h0, 48'h0);
        send_item(FN_ENQ, 48'd0, 16'h9, 40'h9, 48'd0);
        send_item(FN_REQ, 48'd50, 16'hA, 40'hA, 48'd1);
        send_item(FN_REQ, 48'd50, 16'hB, 40'hB, 48'd60);
        send_item(FN_DEQ, 48'hFFFF_FFFF_FFFF, 16'h0, 40'h0, 48'h0);
        send_item(FN_SHUT, 48'd0, 16'h0, 40'h0, 48'h0);
        for (int k = 0; k < 40; k++)
            send_item(t_func'($urandom_range(3)), rand48(), 16'($urandom()), rand40(),
                      rand48());
    endtask

    initial begin
        ready_q.delete();
        heap_n = 0; byte_sum = '0; shut_seen = 1'b0; limit_reg = '0; clock_now = '0;
        errors = 0; checked = 0; dq_hits = 0; promos = 0; no_idle = 1'b0; cycles = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_stores();
        test_random(120, 9'd0);
        test_random(100, 9'd5);
        test_random(100, 9'd511);
        test_shutdown();
        drain_results();
        $display("covered: %0d results checked, %0d items dequeued, %0d retries promoted",
                 checked, dq_hits, promos);
        $display("limit settings 0, 1, 2, 5, 256, 511; full stores, wraparound and shutdown");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ftrh_pkg.sv
sv/ftrh_ram.sv
sv/fifo_with_timed_retry_heap_unit.sv
tb/sv/tb_fifo_with_timed_retry_heap_unit.sv
